// ----- design/ppe_pkg.sv -----
// ----------------------------------------------------------------------------
// Partial permutation enumerator package
// Shared types for the used-mark scan unit and the register index codes.
// ----------------------------------------------------------------------------
package ppe_pkg;

	// Wide enough for any value index and for the set size itself.
	localparam int MARK_W = 9;

	// Configuration register indexes.
	localparam logic REG_N_TOTAL = 1'b0;
	localparam logic REG_M_PICK  = 1'b1;

	// Commands from the sequencer to the used-mark scan unit.
	typedef struct packed {
		logic              clear_all;
		logic              release_en;
		logic [MARK_W-1:0] release_idx;
		logic              claim_en;
		logic [MARK_W-1:0] claim_idx;
		logic              load;
		logic [MARK_W-1:0] load_val;
		logic              adv;
	} marks_cmd_t;

	// Status of the scan pointer as seen by the sequencer.
	typedef struct packed {
		logic              stop;
		logic              in_range;
		logic [MARK_W-1:0] value;
	} marks_stat_t;

endpackage

// ----- design/ppe_marks.sv -----
// ----------------------------------------------------------------------------
// Used-mark store and scan unit
// One used bit per value; the scan pointer steps one value a cycle on advance.
// ----------------------------------------------------------------------------
module ppe_marks #(
	parameter int MAX_N = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(MAX_N+1)-1:0]   n_eff,
	input  ppe_pkg::marks_cmd_t          cmd,
	output ppe_pkg::marks_stat_t         stat
);
	import ppe_pkg::*;

	localparam int NW = $clog2(MAX_N + 1);
	localparam int IW = $clog2(MAX_N);

	logic [MAX_N-1:0] used_q;
	logic [NW-1:0]    scan_q;
	logic             in_range;

	// The scan stops on a free value or at the end of the set.
	assign in_range      = scan_q < n_eff;
	assign stat.in_range = in_range;
	assign stat.stop     = !(in_range && used_q[scan_q[IW-1:0]]);
	assign stat.value    = MARK_W'(scan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clear_all) begin
			used_q <= '0;
		end else begin
			if (cmd.release_en) begin
				used_q[cmd.release_idx[IW-1:0]] <= 1'b0;
			end
			if (cmd.claim_en) begin
				used_q[cmd.claim_idx[IW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (cmd.load) begin
			scan_q <= NW'(cmd.load_val);
		end else if (cmd.adv) begin
			scan_q <= scan_q + NW'(1);
		end
	end

endmodule

// ----- design/partial_permutation_enumerator_unit.sv -----
// ----------------------------------------------------------------------------
// Partial permutation enumerator
// Lists ordered selections of m distinct values from 0..n-1 in lexicographic
// order, one selection per request, one element per output transfer.
// ----------------------------------------------------------------------------
// Sequence: an accepted request, filling of the free slots, a snapshot, stepping
// back slot by slot with a backtracking scan, then m output transfers of the
// snapshot as the result side allows.
// Throughput: one request at a time through the single scan pointer, which looks
// at one value a cycle.
// Reset: asynchronous, active low; n_total is 4, m_pick 2, the enumeration empty.
module partial_permutation_enumerator_unit #(
	parameter int MAX_N = 64,
	parameter int MAX_M = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration write port
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       restart,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [5:0] element_value,
	output logic [3:0] position,
	output logic       last_of_selection,
	output logic       final_selection,
	output logic       exhausted
);
	import ppe_pkg::*;

	localparam int NW = $clog2(MAX_N + 1);
	localparam int IW = $clog2(MAX_N);
	localparam int MW = $clog2(MAX_M + 1);
	localparam int SW = (MAX_M > 1) ? $clog2(MAX_M) : 1;

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FILL   = 3'd1;
	localparam logic [2:0] S_SNAP   = 3'd2;
	localparam logic [2:0] S_POP    = 3'd3;
	localparam logic [2:0] S_BTSCAN = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_EXH    = 3'd6;

	logic [2:0]    state_q;
	logic [6:0]    n_total_q;
	logic [4:0]    m_pick_q;
	logic [MW-1:0] m_q;
	logic [MW-1:0] slot_q;
	logic [MW-1:0] fill_q;
	logic [MW-1:0] emit_q;
	logic          done_q;
	logic          started_q;

	logic [IW-1:0] chosen_q [MAX_M];
	logic [IW-1:0] snap_q   [MAX_M];

	logic          out_valid_q;
	logic [5:0]    element_value_q;
	logic [3:0]    position_q;
	logic          last_q;
	logic          final_q;
	logic          exhausted_q;

	logic [NW-1:0] n_eff;
	logic          m_bad;
	logic          in_xfer;
	logic          out_free;
	logic          fresh;
	logic [MW-1:0] fill_eff;
	logic          done_eff;
	logic [IW-1:0] slot_val;
	logic [IW-1:0] fill_val;
	logic          emit_last;

	marks_cmd_t    mcmd;
	marks_stat_t   mstat;

	// Set size saturates at the largest value the mark store can hold.
	assign n_eff = (32'(n_total_q) > 32'(MAX_N)) ? NW'(MAX_N) : NW'(n_total_q);

	// A selection is impossible when m is zero, too large for the slot store
	// or larger than the set.
	assign m_bad = (m_pick_q == 5'd0) || (32'(m_pick_q) > 32'(MAX_M))
		|| (32'(m_pick_q) > 32'(n_eff));

	// New requests are only taken between selections.
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// The output register is free when empty or when its result transfers now.
	assign out_free = !out_valid_q || !out_stall;

	// The first request after a clear sees an empty enumeration.
	assign fresh    = !started_q;
	assign fill_eff = fresh ? '0 : fill_q;
	assign done_eff = started_q && done_q;

	assign slot_val  = chosen_q[slot_q[SW-1:0]];
	// Filling never runs off the end when m fits in n; the clamp mirrors the
	// end-of-set rule all the same.
	assign fill_val  = mstat.in_range ? IW'(mstat.value) : IW'(n_eff - NW'(1));
	assign emit_last = (emit_q + MW'(1)) == m_q;

	// Commands to the mark store and scan pointer.
	always_comb begin
		mcmd = '0;
		if (cfg_we) begin
			mcmd.clear_all = 1'b1;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (restart || fresh) begin
						mcmd.clear_all = 1'b1;
					end
					mcmd.load = 1'b1;
				end
			end
			S_FILL: begin
				if (!mstat.stop) begin
					mcmd.adv = 1'b1;
				end else begin
					mcmd.claim_en  = 1'b1;
					mcmd.claim_idx = MARK_W'(fill_val);
					mcmd.load      = 1'b1;
				end
			end
			S_POP: begin
				// Slots below m give their value back as the search retreats.
				if (slot_q < m_q) begin
					mcmd.release_en  = 1'b1;
					mcmd.release_idx = MARK_W'(slot_val);
				end
				if (slot_q != '0) begin
					mcmd.load     = 1'b1;
					mcmd.load_val = MARK_W'(chosen_q[SW'(slot_q - MW'(1))]) + MARK_W'(1);
				end
			end
			S_BTSCAN: begin
				if (!mstat.stop) begin
					mcmd.adv = 1'b1;
				end else if (mstat.in_range) begin
					mcmd.release_en  = 1'b1;
					mcmd.release_idx = MARK_W'(slot_val);
					mcmd.claim_en    = 1'b1;
					mcmd.claim_idx   = mstat.value;
				end
			end
			default: begin
			end
		endcase
	end

	ppe_marks #(
		.MAX_N (MAX_N)
	) u_marks (
		.clk    (clk),
		.arst_n (arst_n),
		.n_eff  (n_eff),
		.cmd    (mcmd),
		.stat   (mstat)
	);

	// Configuration registers; any write also clears the enumeration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_total_q <= 7'd4;
			m_pick_q  <= 5'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_N_TOTAL: n_total_q <= cfg_data;
				REG_M_PICK:  m_pick_q  <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_q       <= '0;
			slot_q    <= '0;
			fill_q    <= '0;
			emit_q    <= '0;
			done_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (cfg_we) begin
			fill_q    <= '0;
			done_q    <= 1'b0;
			started_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (restart) begin
							fill_q    <= '0;
							done_q    <= 1'b0;
							started_q <= 1'b0;
						end else begin
							started_q <= 1'b1;
							fill_q    <= fill_eff;
							done_q    <= done_eff;
							if (done_eff || m_bad) begin
								state_q <= S_EXH;
							end else begin
								m_q    <= MW'(m_pick_q);
								slot_q <= fill_eff;
								if (fill_eff < MW'(m_pick_q)) begin
									state_q <= S_FILL;
								end else begin
									state_q <= S_SNAP;
								end
							end
						end
					end
				end
				S_FILL: begin
					if (mstat.stop) begin
						if ((slot_q + MW'(1)) == m_q) begin
							fill_q  <= m_q;
							state_q <= S_SNAP;
						end else begin
							slot_q <= slot_q + MW'(1);
						end
					end
				end
				S_SNAP: begin
					slot_q  <= m_q;
					state_q <= S_POP;
				end
				S_POP: begin
					if (slot_q == '0) begin
						// Nothing left to advance: this was the last selection.
						done_q  <= 1'b1;
						fill_q  <= '0;
						emit_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						slot_q  <= slot_q - MW'(1);
						state_q <= S_BTSCAN;
					end
				end
				S_BTSCAN: begin
					if (mstat.stop) begin
						if (mstat.in_range) begin
							fill_q  <= slot_q + MW'(1);
							emit_q  <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							emit_q <= emit_q + MW'(1);
						end
					end
				end
				S_EXH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Slot store and the snapshot that is emitted while the next selection is
	// already prepared.
	always_ff @(posedge clk) begin
		if (state_q == S_FILL && mstat.stop) begin
			chosen_q[slot_q[SW-1:0]] <= fill_val;
		end
		if (state_q == S_BTSCAN && mstat.stop && mstat.in_range) begin
			chosen_q[slot_q[SW-1:0]] <= IW'(mstat.value);
		end
		if (state_q == S_SNAP) begin
			snap_q <= chosen_q;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_EMIT || state_q == S_EXH) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_EMIT) begin
				element_value_q <= 6'(snap_q[emit_q[SW-1:0]]);
				position_q      <= 4'(emit_q);
				last_q          <= emit_last;
				final_q         <= done_q;
				exhausted_q     <= 1'b0;
			end else if (state_q == S_EXH) begin
				element_value_q <= '0;
				position_q      <= '0;
				last_q          <= 1'b0;
				final_q         <= 1'b0;
				exhausted_q     <= 1'b1;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign element_value     = element_value_q;
	assign position          = position_q;
	assign last_of_selection = last_q;
	assign final_selection   = final_q;
	assign exhausted         = exhausted_q;

	// An exhausted result carries no element.
	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exhausted) |-> (element_value == 6'd0 && position == 4'd0
			&& !last_of_selection && !final_selection))
		else $error("exhausted result carries element data");

	// The flagged element sits in the last slot of the selection.
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !exhausted && last_of_selection) |-> (position == 4'(m_q - MW'(1))))
		else $error("last element not in final slot");

	// A restart leaves the enumeration empty and the sequencer idle.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && restart && !cfg_we)
			|=> (state_q == S_IDLE && !started_q && fill_q == '0))
		else $error("restart did not clear the enumeration");

	// Between requests the fill depth never passes the slot count in use.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && started_q) |-> (fill_q <= m_q))
		else $error("fill depth beyond slot count");

endmodule
